// ===== rtl/chs_pkg.sv =====
// Shared types and constants of the cuckoo hash set.
`default_nettype none

package chs_pkg;

	localparam int KEY_W     = 64;
	localparam int HALF_W    = KEY_W / 2;
	localparam int SEED_W    = 10;
	localparam int ROUND_W   = 7;
	localparam int CFG_IDX_W = 2;
	localparam int STAT_W    = 3;
	localparam int CMD_W     = 2;

	localparam logic [ROUND_W-1:0] ROUNDS_RESET = 7'd33;

	// hash multipliers, masked down to the index width where used
	localparam logic [KEY_W-1:0] MULT_ONE = 64'h517c_c1b7_2722_0a95;
	localparam logic [KEY_W-1:0] MULT_TWO = 64'hbf58_476d_1ce4_e5b9;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_MISS    = 3'd0,
		STAT_HIT     = 3'd1,
		STAT_PLACED  = 3'd2,
		STAT_PRESENT = 3'd3,
		STAT_FAILED  = 3'd4,
		STAT_ZERO    = 3'd5,
		STAT_CLEARED = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED_ONE   = 2'd0,
		CFG_SEED_TWO   = 2'd1,
		CFG_MAX_ROUNDS = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_CHECK,
		S_RD1,
		S_WR1,
		S_HASH2,
		S_RD2,
		S_WR2,
		S_HASH1,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_key;
		logic    hash_one;
		logic    hash_two;
		logic    rd_one;
		logic    rd_two;
		logic    wr_one;
		logic    wr_two;
		logic    sweep;
		logic    round_clr;
		logic    round_inc;
		logic    set_status;
		status_t status;
		logic    out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_key_zero;
		logic hit;
		logic rd_one_zero;
		logic rd_two_zero;
		logic sweep_last;
		logic round_last;
		logic rounds_none;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/chs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module chs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/chs_datapath.sv =====
// Datapath: config registers, hash units, both tables, sweep and round counters, result register.
`default_nettype none

module chs_datapath import chs_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_data,
	input  logic [KEY_W-1:0]     in_key,
	input  dp_cmd_t              dp_cmd,
	output dp_sts_t              dp_sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STAT_W-1:0]    out_status,
	output logic [KEY_W-1:0]     out_key
);

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int EXT_W = (INDEX_BITS > SEED_W) ? INDEX_BITS : SEED_W;
	localparam logic [INDEX_BITS-1:0] MUL1 = MULT_ONE[INDEX_BITS-1:0];
	localparam logic [INDEX_BITS-1:0] MUL2 = MULT_TWO[INDEX_BITS-1:0];

	logic [SEED_W-1:0]     seed_one_q;
	logic [SEED_W-1:0]     seed_two_q;
	logic [ROUND_W-1:0]    max_rounds_q;
	logic [KEY_W-1:0]      key_q;
	logic [KEY_W-1:0]      carried_q;
	logic [INDEX_BITS-1:0] idx1_q;
	logic [INDEX_BITS-1:0] idx2_q;
	logic [INDEX_BITS-1:0] sweep_q;
	logic [ROUND_W-1:0]    round_q;
	status_t               status_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [KEY_W-1:0]      out_key_q;

	logic [EXT_W-1:0]        seed1_ext;
	logic [EXT_W-1:0]        seed2_ext;
	logic [INDEX_BITS-1:0]   fold1;
	logic [INDEX_BITS-1:0]   fold2;
	logic [2*INDEX_BITS-1:0] prod1;
	logic [2*INDEX_BITS-1:0] prod2;
	logic [KEY_W-1:0]        rdata1;
	logic [KEY_W-1:0]        rdata2;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q   <= '0;
			seed_two_q   <= '0;
			max_rounds_q <= ROUNDS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SEED_ONE:   seed_one_q   <= cfg_data;
				CFG_SEED_TWO:   seed_two_q   <= cfg_data;
				CFG_MAX_ROUNDS: max_rounds_q <= cfg_data[ROUND_W-1:0];
				default: ;
			endcase
		end
	end

	// hash: fold halves and seed, multiply by masked constant
	assign seed1_ext = EXT_W'(seed_one_q);
	assign seed2_ext = EXT_W'(seed_two_q);
	assign fold1 = carried_q[HALF_W +: INDEX_BITS] ^ carried_q[INDEX_BITS-1:0]
		^ seed1_ext[INDEX_BITS-1:0];
	assign fold2 = carried_q[HALF_W +: INDEX_BITS] ^ carried_q[INDEX_BITS-1:0]
		^ seed2_ext[INDEX_BITS-1:0];
	assign prod1 = fold1 * MUL1;
	assign prod2 = fold2 * MUL2;

	always_ff @(posedge clk) begin
		if (dp_cmd.load_key) begin
			key_q     <= in_key;
			carried_q <= in_key;
		end else if (dp_cmd.wr_one) begin
			carried_q <= rdata1;
		end else if (dp_cmd.wr_two) begin
			carried_q <= rdata2;
		end
		if (dp_cmd.hash_one) begin
			idx1_q <= prod1[INDEX_BITS-1:0];
		end
		if (dp_cmd.hash_two) begin
			idx2_q <= prod2[INDEX_BITS-1:0];
		end
		if (dp_cmd.set_status) begin
			status_q <= dp_cmd.status;
		end
		if (dp_cmd.out_load) begin
			out_status_q <= status_q;
			out_key_q    <= (status_q == STAT_FAILED) ? carried_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.sweep) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (dp_cmd.round_clr) begin
				round_q <= '0;
			end else if (dp_cmd.round_inc) begin
				round_q <= round_q + 1'b1;
			end
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	chs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_first (
		.clk  (clk),
		.we   (dp_cmd.wr_one | dp_cmd.sweep),
		.waddr(dp_cmd.sweep ? sweep_q : idx1_q),
		.wdata(dp_cmd.sweep ? '0 : carried_q),
		.re   (dp_cmd.rd_one),
		.raddr(idx1_q),
		.rdata(rdata1)
	);

	chs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_second (
		.clk  (clk),
		.we   (dp_cmd.wr_two | dp_cmd.sweep),
		.waddr(dp_cmd.sweep ? sweep_q : idx2_q),
		.wdata(dp_cmd.sweep ? '0 : carried_q),
		.re   (dp_cmd.rd_two),
		.raddr(idx2_q),
		.rdata(rdata2)
	);

	always_comb begin
		dp_sts.in_key_zero = (in_key == '0);
		dp_sts.hit         = (rdata1 == key_q) || (rdata2 == key_q);
		dp_sts.rd_one_zero = (rdata1 == '0);
		dp_sts.rd_two_zero = (rdata2 == '0);
		dp_sts.sweep_last  = (sweep_q == '1);
		dp_sts.round_last  = ({1'b0, round_q} + 1'b1) >= {1'b0, max_rounds_q};
		dp_sts.rounds_none = (max_rounds_q == '0);
		dp_sts.out_busy    = out_valid_q & ~out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_key    = out_key_q;

	a_no_empty_store: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.wr_one || dp_cmd.wr_two) |-> (carried_q != '0))
		else $error("displacement stores an empty key");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.wr_two |-> (round_q < max_rounds_q))
		else $error("displacement round beyond the limit");

	a_homeless_only_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |=> ((out_key != '0) == (out_status == STAT_FAILED)))
		else $error("homeless key does not match the failure status");

endmodule

`default_nettype wire

// ===== rtl/chs_ctrl.sv =====
// Controller: sequences lookups, inserts with displacement rounds and table sweeps.
`default_nettype none

module chs_ctrl import chs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [CMD_W-1:0] in_cmd,
	output dp_cmd_t          dp_cmd,
	input  dp_sts_t          dp_sts
);

	state_t state_q, state_d;
	cmd_t   op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			op_q    <= CMD_NONE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		dp_cmd   = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				dp_cmd.sweep = 1'b1;
				if (dp_sts.sweep_last) begin
					if (op_q == CMD_CLEAR) begin
						dp_cmd.set_status = 1'b1;
						dp_cmd.status     = STAT_CLEARED;
						state_d           = S_FINISH;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op_d            = cmd_t'(in_cmd);
					dp_cmd.load_key = 1'b1;
					case (cmd_t'(in_cmd))
						CMD_CLEAR: state_d = S_CLEAR;
						CMD_NONE: begin
							dp_cmd.set_status = 1'b1;
							dp_cmd.status     = STAT_MISS;
							state_d           = S_FINISH;
						end
						default: begin
							if (dp_sts.in_key_zero) begin
								dp_cmd.set_status = 1'b1;
								dp_cmd.status     = STAT_ZERO;
								state_d           = S_FINISH;
							end else begin
								state_d = S_HASH;
							end
						end
					endcase
				end
			end
			S_HASH: begin
				dp_cmd.hash_one = 1'b1;
				dp_cmd.hash_two = 1'b1;
				state_d         = S_PROBE;
			end
			S_PROBE: begin
				dp_cmd.rd_one = 1'b1;
				dp_cmd.rd_two = 1'b1;
				state_d       = S_CHECK;
			end
			S_CHECK: begin
				dp_cmd.set_status = 1'b1;
				if (dp_sts.hit) begin
					dp_cmd.status = (op_q == CMD_LOOKUP) ? STAT_HIT : STAT_PRESENT;
					state_d       = S_FINISH;
				end else if (op_q == CMD_LOOKUP) begin
					dp_cmd.status = STAT_MISS;
					state_d       = S_FINISH;
				end else if (dp_sts.rounds_none) begin
					dp_cmd.status = STAT_FAILED;
					state_d       = S_FINISH;
				end else begin
					dp_cmd.set_status = 1'b0;
					dp_cmd.round_clr  = 1'b1;
					state_d           = S_RD1;
				end
			end
			S_RD1: begin
				dp_cmd.rd_one = 1'b1;
				state_d       = S_WR1;
			end
			S_WR1: begin
				dp_cmd.wr_one = 1'b1;
				if (dp_sts.rd_one_zero) begin
					dp_cmd.set_status = 1'b1;
					dp_cmd.status     = STAT_PLACED;
					state_d           = S_FINISH;
				end else begin
					state_d = S_HASH2;
				end
			end
			S_HASH2: begin
				dp_cmd.hash_two = 1'b1;
				state_d         = S_RD2;
			end
			S_RD2: begin
				dp_cmd.rd_two = 1'b1;
				state_d       = S_WR2;
			end
			S_WR2: begin
				dp_cmd.wr_two = 1'b1;
				if (dp_sts.rd_two_zero) begin
					dp_cmd.set_status = 1'b1;
					dp_cmd.status     = STAT_PLACED;
					state_d           = S_FINISH;
				end else if (dp_sts.round_last) begin
					dp_cmd.set_status = 1'b1;
					dp_cmd.status     = STAT_FAILED;
					state_d           = S_FINISH;
				end else begin
					dp_cmd.round_inc = 1'b1;
					state_d          = S_HASH1;
				end
			end
			S_HASH1: begin
				dp_cmd.hash_one = 1'b1;
				state_d         = S_RD1;
			end
			S_FINISH: begin
				if (!dp_sts.out_busy) begin
					dp_cmd.out_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> !dp_sts.out_busy)
		else $error("result loaded over an untaken word");

	a_sweep_runs_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && !dp_sts.sweep_last) |=> (state_q == S_CLEAR))
		else $error("table sweep left before its last entry");

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_key |-> (s_tvalid && s_tready))
		else $error("key loaded without an accepted word");

endmodule

`default_nettype wire

// ===== rtl/cuckoo_hash_set_top.sv =====
// Top level of the two-table cuckoo hash set with stream and config ports.
// Path, accept to result: a zero key or unused command goes straight to the result word;
//   lookups and inserts hash, probe and check; an insert then displaces, each further table
//   visited costing hash, registered RAM read, write-back. A clear sweeps one entry a cycle.
// One item is in work at a time; the next is taken while the result word waits.
// After reset a sweep empties both tables with s_tready low;
//   config registers reset to seeds 0 and 33 rounds and are writable throughout.
`default_nettype none

module cuckoo_hash_set_top import chs_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_data,
	// input word
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [KEY_W-1:0]     s_tdata,   // [63:0] key
	input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
	// result word
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [KEY_W-1:0]     m_tdata,   // [63:0] homeless_key
	output logic [STAT_W-1:0]    m_tuser    // [2:0] status
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// config writes go straight into the registers, so never hold the channel
	assign cfg_ready = 1'b1;

	// sequence each word: probe, displace, sweep, hand to result register
	chs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_cmd  (s_tuser),
		.dp_cmd  (dp_cmd),
		.dp_sts  (dp_sts)
	);

	// tables, hashes and the result register that parts the output side
	chs_datapath #(
		.INDEX_BITS(INDEX_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_key    (s_tdata),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(m_tuser),
		.out_key   (m_tdata)
	);

endmodule

`default_nettype wire

// ===== bench/cuckoo_hash_set_checker.sv =====
`timescale 1ns / 100ps
// Watches the config, input and result channels of the cuckoo hash set and checks every result word.
module cuckoo_hash_set_checker import chs_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [KEY_W-1:0]     s_tdata,   // [63:0] key
	input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [KEY_W-1:0]     m_tdata,   // [63:0] homeless_key
	input  logic [STAT_W-1:0]    m_tuser,   // [2:0] status
	output int unsigned          mismatches,
	output int unsigned          awaiting
);

	localparam int DEPTH = 1 << INDEX_BITS;

	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] homeless;
	} verdict_t;

	logic [KEY_W-1:0]   first_slots [DEPTH];
	logic [KEY_W-1:0]   second_slots [DEPTH];
	logic [SEED_W-1:0]  seed_one;
	logic [SEED_W-1:0]  seed_two;
	logic [ROUND_W-1:0] round_limit;
	verdict_t           verdicts [$];
	verdict_t           due;

	function automatic logic [INDEX_BITS-1:0] slot_of(input logic [KEY_W-1:0] key,
			input logic [SEED_W-1:0] seed, input logic [KEY_W-1:0] mult);
		logic [INDEX_BITS-1:0]   folded;
		logic [2*INDEX_BITS-1:0] product;
		folded = key[HALF_W +: INDEX_BITS] ^ key[INDEX_BITS-1:0] ^ INDEX_BITS'(seed);
		product = folded * mult[INDEX_BITS-1:0];
		return product[INDEX_BITS-1:0];
	endfunction

	function automatic logic stored(input logic [KEY_W-1:0] key);
		return first_slots[slot_of(key, seed_one, MULT_ONE)] == key ||
			second_slots[slot_of(key, seed_two, MULT_TWO)] == key;
	endfunction

	function automatic void clear_tables();
		foreach (first_slots[i]) begin
			first_slots[i] = '0;
			second_slots[i] = '0;
		end
	endfunction

	// Apply one input word to the mirrored tables and give the result it must cause.
	function automatic verdict_t apply_item(input cmd_t cmd, input logic [KEY_W-1:0] key);
		verdict_t              v;
		logic [KEY_W-1:0]      carried;
		logic [KEY_W-1:0]      swap;
		logic [INDEX_BITS-1:0] slot;
		int unsigned           round;
		logic                  settled;
		v.status = STAT_MISS;
		v.homeless = '0;
		if (cmd == CMD_CLEAR) begin
			clear_tables();
			v.status = STAT_CLEARED;
		end else if (cmd == CMD_NONE) begin
			v.status = STAT_MISS;
		end else if (key == '0) begin
			v.status = STAT_ZERO;
		end else if (cmd == CMD_LOOKUP) begin
			v.status = stored(key) ? STAT_HIT : STAT_MISS;
		end else if (stored(key)) begin
			v.status = STAT_PRESENT;
		end else begin
			carried = key;
			settled = 1'b0;
			round = 0;
			while (!settled && round < round_limit) begin
				slot = slot_of(carried, seed_one, MULT_ONE);
				swap = first_slots[slot];
				first_slots[slot] = carried;
				carried = swap;
				if (carried == '0) begin
					settled = 1'b1;
				end else begin
					slot = slot_of(carried, seed_two, MULT_TWO);
					swap = second_slots[slot];
					second_slots[slot] = carried;
					carried = swap;
					settled = (carried == '0);
				end
				round++;
			end
			if (settled) begin
				v.status = STAT_PLACED;
			end else begin
				v.status = STAT_FAILED;
				v.homeless = carried;
			end
		end
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40) begin
			$display("%0t ns: %s", $time, what);
		end
		mismatches++;
	endtask

	// Results are taken before the input of the same edge: a result word always
	// belongs to an item accepted earlier.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tables();
			seed_one = '0;
			seed_two = '0;
			round_limit = ROUNDS_RESET;
			verdicts.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SEED_ONE: seed_one = cfg_data;
					CFG_SEED_TWO: seed_two = cfg_data;
					CFG_MAX_ROUNDS: round_limit = cfg_data[ROUND_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (verdicts.size() == 0) begin
					report_mismatch($sformatf("result word (status %0d) with none outstanding",
						m_tuser));
				end else begin
					due = verdicts.pop_front();
					if (m_tuser !== due.status) begin
						report_mismatch($sformatf("status %0d, want %0d", m_tuser, due.status));
					end
					if (m_tdata !== due.homeless) begin
						report_mismatch($sformatf("homeless key %h, want %h", m_tdata,
							due.homeless));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				verdicts.push_back(apply_item(cmd_t'(s_tuser), s_tdata));
			end
		end
		awaiting = verdicts.size();
	end

endmodule

// ===== bench/cuckoo_hash_set_top_tb.sv =====
`timescale 1ns / 100ps
// Top of the cuckoo hash set testbench: clock, reset, stimulus and the final verdict.
module cuckoo_hash_set_top_tb import chs_pkg::*; ();

	localparam int INDEX_BITS      = 10;
	localparam int LIMIT_NS        = 4_000_000;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int POOL_DEPTH      = 64;
	localparam logic [KEY_W-1:0] ALL_ONES = '1;
	// these fold to the same slots as each other and as ALL_ONES, so they evict one another
	localparam logic [KEY_W-1:0] KEY_A = 64'h0000_0000_0000_0400;
	localparam logic [KEY_W-1:0] KEY_B = 64'h0000_0000_0000_0800;
	localparam logic [KEY_W-1:0] KEY_C = 64'h0000_0000_0000_1000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SEED_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [KEY_W-1:0]     s_tdata = '0;   // [63:0] key
	logic [CMD_W-1:0]     s_tuser = '0;   // [1:0] cmd
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [KEY_W-1:0]     m_tdata;        // [63:0] homeless_key
	logic [STAT_W-1:0]    m_tuser;        // [2:0] status

	int unsigned      mismatches;
	int unsigned      awaiting;
	int unsigned      send_idle_pct = 25;
	int unsigned      take_idle_pct = 70;
	logic [KEY_W-1:0] known_keys [$];

	cuckoo_hash_set_top #(
		.INDEX_BITS(INDEX_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cuckoo_hash_set_checker #(
		.INDEX_BITS(INDEX_BITS)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.mismatches(mismatches),
		.awaiting  (awaiting)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random; a zero percentage keeps ready high throughout.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= take_idle_pct);
	end

	// Hold off until every expected result word has been taken; return on a rising edge.
	task automatic wait_idle();
		do @(negedge clk); while (awaiting != 0);
		@(posedge clk);
	endtask

	// Hold one register write until the block takes it; valid is left high for the next one.
	task automatic write_reg(input cfg_idx_t idx, input logic [SEED_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// Drop the input side, drain the block, then write all three registers.
	task automatic set_registers(input logic [SEED_W-1:0] first_seed,
			input logic [SEED_W-1:0] second_seed, input logic [SEED_W-1:0] rounds);
		s_tvalid <= 1'b0;
		wait_idle();
		write_reg(CFG_SEED_ONE, first_seed);
		write_reg(CFG_SEED_TWO, second_seed);
		write_reg(CFG_MAX_ROUNDS, rounds);
		cfg_valid <= 1'b0;
	endtask

	// Offer one input word after a random gap and hold it until accepted.
	task automatic send_item(input cmd_t cmd, input logic [KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= key;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	// A crowded key has both hashed fields squeezed into eight values, so that such keys
	// pile up on a handful of slots and drive long eviction chains and failures.
	function automatic logic [KEY_W-1:0] fresh_key(input bit crowded);
		logic [KEY_W-1:0] k;
		k = {$urandom, $urandom};
		if (crowded) begin
			k[HALF_W +: INDEX_BITS] = INDEX_BITS'($urandom_range(7));
			k[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(7));
		end
		if (k == '0) begin
			k[KEY_W-1] = 1'b1;
		end
		return k;
	endfunction

	// Mostly inserts and lookups, many of keys already seen so that hits and
	// duplicates are common; a sprinkle of clears, unused commands and zero keys.
	task automatic random_item();
		int unsigned      dice;
		logic [KEY_W-1:0] k;
		dice = $urandom_range(99);
		if (dice < 3) begin
			send_item(CMD_CLEAR, {$urandom, $urandom});
		end else if (dice < 6) begin
			send_item(CMD_NONE, {$urandom, $urandom});
		end else if (dice < 8) begin
			send_item(dice[0] ? CMD_INSERT : CMD_LOOKUP, '0);
		end else if (dice < 32) begin
			if (known_keys.size() != 0 && $urandom_range(99) < 70) begin
				k = known_keys[$urandom_range(known_keys.size() - 1)];
			end else begin
				k = fresh_key(bit'($urandom_range(1)));
			end
			send_item(CMD_LOOKUP, k);
		end else begin
			if (known_keys.size() != 0 && $urandom_range(99) < 20) begin
				k = known_keys[$urandom_range(known_keys.size() - 1)];
			end else begin
				k = fresh_key($urandom_range(99) < 40);
				known_keys.push_back(k);
				if (known_keys.size() > POOL_DEPTH) begin
					void'(known_keys.pop_front());
				end
			end
			send_item(CMD_INSERT, k);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one round only, so the third colliding key already fails.
		set_registers(10'd0, 10'h3FF, 10'd1);
		send_item(CMD_LOOKUP, '0);
		send_item(CMD_INSERT, '0);
		send_item(CMD_NONE, ALL_ONES);
		send_item(CMD_LOOKUP, ALL_ONES);
		send_item(CMD_INSERT, ALL_ONES);
		send_item(CMD_INSERT, ALL_ONES);
		send_item(CMD_LOOKUP, ALL_ONES);
		send_item(CMD_INSERT, KEY_A);      // pushes ALL_ONES into the second table
		send_item(CMD_LOOKUP, ALL_ONES);
		send_item(CMD_INSERT, KEY_B);      // evicts ALL_ONES for good
		send_item(CMD_LOOKUP, ALL_ONES);

		// No rounds at all: an absent key comes straight back as homeless.
		set_registers(10'd0, 10'h3FF, 10'd0);
		send_item(CMD_INSERT, KEY_C);
		send_item(CMD_INSERT, KEY_A);
		send_item(CMD_LOOKUP, KEY_C);

		// All ten data bits set: only the low seven count, and the chain cycles to the end.
		set_registers(10'd0, 10'h3FF, 10'h3FF);
		send_item(CMD_INSERT, ALL_ONES);
		send_item(CMD_CLEAR, {$urandom, $urandom});
		send_item(CMD_LOOKUP, KEY_B);
		send_item(CMD_INSERT, KEY_B);
		send_item(CMD_LOOKUP, KEY_B);

		// Random: three phases, each with its own settings and stall pattern.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					set_registers(SEED_W'($urandom), SEED_W'($urandom), 10'd64);
					send_idle_pct = 25;
					take_idle_pct = 70;
				end
				1: begin
					set_registers(10'h3FF, 10'h3FF, 10'd1);
					send_idle_pct = 70;
					take_idle_pct = 25;
				end
				default: begin
					set_registers(SEED_W'($urandom), SEED_W'($urandom),
						SEED_W'($urandom_range(64, 1)));
					send_idle_pct = 0;
					take_idle_pct = 0;
				end
			endcase
			repeat (ITEMS_PER_PHASE) random_item();
		end

		// Drain, leave a short tail for anything stray, then give the verdict.
		s_tvalid <= 1'b0;
		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("cuckoo_hash_set_top_tb passed");
		end else begin
			$display("cuckoo_hash_set_top_tb failed");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(LIMIT_NS);
		$display("cuckoo_hash_set_top_tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/chs_pkg.sv
rtl/chs_ram.sv
rtl/chs_datapath.sv
rtl/chs_ctrl.sv
rtl/cuckoo_hash_set_top.sv
bench/cuckoo_hash_set_checker.sv
bench/cuckoo_hash_set_top_tb.sv
